// ===== hw/rtl/sdcb_pkg.sv =====
package sdcb_pkg;

    localparam int MAX_SEGMENTS_DEFAULT        = 8;
    localparam int SECTORS_PER_SEGMENT_DEFAULT = 16;

    // 512-byte sectors
    localparam int SECTOR_SHIFT = 9;

    localparam logic [31:0] VIRTUAL_OFFSET_RESET = 32'hC000_0000;

    localparam logic [5:0] CMD_READ_DMA_EXT  = 6'h25;
    localparam logic [5:0] CMD_WRITE_DMA_EXT = 6'h35;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_SLOT   = 2'd1,
        STATUS_BAD_COUNT = 2'd2
    } status_t;

    typedef struct packed {
        logic load;        // capture request
        logic check;       // pick slot, seed entry count
        logic count_step;  // one more entry needed
        logic emit_start;  // rewind for the emit pass
        logic emit;        // put out one entry word
        logic emit_err;    // put out the error word
    } dp_cmd_t;

    typedef struct packed {
        logic no_slot;
        logic bad_count;
        logic more;        // remaining sectors exceed one entry
    } dp_stat_t;

endpackage

// ===== hw/rtl/sdcb_ctrl.sv =====
module sdcb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               result_strobe,
    output sdcb_pkg::dp_cmd_t  cmd,
    input  sdcb_pkg::dp_stat_t stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COUNT,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   strobe_reg;
    logic   strobe_next;

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        strobe_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.no_slot || stat.bad_count)
                begin
                    cmd.emit_err = 1'b1;
                    strobe_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (stat.more)
                begin
                    cmd.count_step = 1'b1;
                end
                else
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit    = 1'b1;
                strobe_next = 1'b1;
                if (!stat.more)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_strobe = strobe_reg;

endmodule

// ===== hw/rtl/sdcb_datapath.sv =====
module sdcb_datapath #(
    parameter int MAX_SEGMENTS        = sdcb_pkg::MAX_SEGMENTS_DEFAULT,
    parameter int SECTORS_PER_SEGMENT = sdcb_pkg::SECTORS_PER_SEGMENT_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sdcb_pkg::dp_cmd_t  cmd,
    output sdcb_pkg::dp_stat_t stat,
    input  logic               cfg_write,
    input  logic [31:0]        cfg_data,
    input  logic               mode,
    input  logic [31:0]        start_sector,
    input  logic [15:0]        sector_count,
    input  logic [31:0]        buffer_address,
    input  logic [31:0]        active_slots,
    input  logic [31:0]        issued_slots,
    output logic [1:0]         status,
    output logic [4:0]         slot,
    output logic [5:0]         command_code,
    output logic [31:0]        fis_sector,
    output logic [15:0]        fis_count,
    output logic [3:0]         entry_total,
    output logic [2:0]         entry_index,
    output logic [31:0]        segment_address,
    output logic [12:0]        byte_count_less_one,
    output logic               last
);

    localparam int SEGW = $clog2(MAX_SEGMENTS + 1);
    localparam int IDXW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int MAX_SECTORS = MAX_SEGMENTS * SECTORS_PER_SEGMENT;
    localparam logic [15:0] SPS = 16'(SECTORS_PER_SEGMENT);
    localparam logic [31:0] SEG_BYTES = 32'(SECTORS_PER_SEGMENT) << sdcb_pkg::SECTOR_SHIFT;

    logic [31:0]     voff_reg;
    logic            mode_reg;
    logic [31:0]     lba_reg;
    logic [15:0]     count_reg;
    logic [31:0]     base_reg;
    logic [31:0]     mask_reg;
    logic [4:0]      slot_reg;
    logic [15:0]     rem_reg;
    logic [SEGW-1:0] segs_reg;
    logic [IDXW-1:0] idx_reg;
    logic [31:0]     addr_reg;

    logic [1:0]      status_reg;
    logic [4:0]      slot_out_reg;
    logic [5:0]      code_reg;
    logic [31:0]     fis_sector_reg;
    logic [15:0]     fis_count_reg;
    logic [3:0]      total_reg;
    logic [2:0]      index_reg;
    logic [31:0]     seg_addr_reg;
    logic [12:0]     bcl1_reg;
    logic            last_reg;

    logic [4:0]      slot_next;
    logic [15:0]     secs;
    logic [24:0]     bytes;

    // lowest slot clear in both masks
    always_comb
    begin
        slot_next = '0;
        for (int k = 31; k >= 0; k--)
        begin
            if (!mask_reg[k])
            begin
                slot_next = 5'(k);
            end
        end
    end

    assign stat.no_slot   = &mask_reg;
    assign stat.bad_count = (count_reg == 16'd0) || (17'(count_reg) > 17'(MAX_SECTORS));
    assign stat.more      = (rem_reg > SPS);

    assign secs  = stat.more ? SPS : rem_reg;
    assign bytes = {secs, {sdcb_pkg::SECTOR_SHIFT{1'b0}}} - 25'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voff_reg <= sdcb_pkg::VIRTUAL_OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            voff_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode;
            lba_reg   <= start_sector;
            count_reg <= sector_count;
            base_reg  <= buffer_address - voff_reg;
            mask_reg  <= active_slots | issued_slots;
        end
        if (cmd.check)
        begin
            slot_reg <= slot_next;
            rem_reg  <= count_reg;
            segs_reg <= SEGW'(1);
        end
        if (cmd.count_step)
        begin
            rem_reg  <= rem_reg - SPS;
            segs_reg <= segs_reg + SEGW'(1);
        end
        if (cmd.emit_start)
        begin
            rem_reg  <= count_reg;
            idx_reg  <= '0;
            addr_reg <= base_reg;
        end
        if (cmd.emit)
        begin
            rem_reg  <= rem_reg - SPS;
            idx_reg  <= idx_reg + IDXW'(1);
            addr_reg <= addr_reg + SEG_BYTES;

            status_reg     <= sdcb_pkg::STATUS_OK;
            slot_out_reg   <= slot_reg;
            code_reg       <= mode_reg ? sdcb_pkg::CMD_WRITE_DMA_EXT
                                       : sdcb_pkg::CMD_READ_DMA_EXT;
            fis_sector_reg <= lba_reg;
            fis_count_reg  <= count_reg;
            total_reg      <= 4'(segs_reg);
            index_reg      <= 3'(idx_reg);
            seg_addr_reg   <= addr_reg;
            bcl1_reg       <= bytes[12:0];
            last_reg       <= !stat.more;
        end
        if (cmd.emit_err)
        begin
            status_reg     <= stat.no_slot ? sdcb_pkg::STATUS_NO_SLOT
                                           : sdcb_pkg::STATUS_BAD_COUNT;
            slot_out_reg   <= '0;
            code_reg       <= '0;
            fis_sector_reg <= '0;
            fis_count_reg  <= '0;
            total_reg      <= '0;
            index_reg      <= '0;
            seg_addr_reg   <= '0;
            bcl1_reg       <= '0;
            last_reg       <= 1'b1;
        end
    end

    assign status              = status_reg;
    assign slot                = slot_out_reg;
    assign command_code        = code_reg;
    assign fis_sector          = fis_sector_reg;
    assign fis_count           = fis_count_reg;
    assign entry_total         = total_reg;
    assign entry_index         = index_reg;
    assign segment_address     = seg_addr_reg;
    assign byte_count_less_one = bcl1_reg;
    assign last                = last_reg;

endmodule

// ===== hw/rtl/sata_dma_command_builder_unit.sv =====
// Builds one DMA EXT command per request: picks the lowest free command slot
// and emits one result word per scatter entry, with last set on the final
// word; a request with no free slot or a bad sector count gives a single error
// word. Result words are shown for one cycle on result_strobe and cannot be
// stalled, so the receiver must take every word as it comes. A good request
// keeps busy high through a check state, a count state in which a subtract
// loop counts the entries, then an emit state that puts out the entry words in
// order. An error request holds busy only for the check state. A new start is
// taken in the cycle the final word is on the ports. Write cfg_data via
// cfg_write only while idle.
module sata_dma_command_builder_unit #(
    parameter int MAX_SEGMENTS        = sdcb_pkg::MAX_SEGMENTS_DEFAULT,
    parameter int SECTORS_PER_SEGMENT = sdcb_pkg::SECTORS_PER_SEGMENT_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [31:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [31:0] start_sector,
    input  logic [15:0] sector_count,
    input  logic [31:0] buffer_address,
    input  logic [31:0] active_slots,
    input  logic [31:0] issued_slots,
    output logic        result_strobe,
    output logic [1:0]  status,
    output logic [4:0]  slot,
    output logic [5:0]  command_code,
    output logic [31:0] fis_sector,
    output logic [15:0] fis_count,
    output logic [3:0]  entry_total,
    output logic [2:0]  entry_index,
    output logic [31:0] segment_address,
    output logic [12:0] byte_count_less_one,
    output logic        last
);

    sdcb_pkg::dp_cmd_t  cmd;
    sdcb_pkg::dp_stat_t stat;

    sdcb_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .result_strobe (result_strobe),
        .cmd           (cmd),
        .stat          (stat)
    );

    sdcb_datapath #(
        .MAX_SEGMENTS        (MAX_SEGMENTS),
        .SECTORS_PER_SEGMENT (SECTORS_PER_SEGMENT)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .stat                (stat),
        .cfg_write           (cfg_write),
        .cfg_data            (cfg_data),
        .mode                (mode),
        .start_sector        (start_sector),
        .sector_count        (sector_count),
        .buffer_address      (buffer_address),
        .active_slots        (active_slots),
        .issued_slots        (issued_slots),
        .status              (status),
        .slot                (slot),
        .command_code        (command_code),
        .fis_sector          (fis_sector),
        .fis_count           (fis_count),
        .entry_total         (entry_total),
        .entry_index         (entry_index),
        .segment_address     (segment_address),
        .byte_count_less_one (byte_count_less_one),
        .last                (last)
    );

endmodule
